// File: rtl/core/dtq_pkg.sv
package dtq_pkg;

    // Idle retry interval reported when the earliest deadline has been reached
    localparam logic [47:0] IDLE_RETRY_MS = 48'd100;

    // Request opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    // Summary status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // One timer slot
    typedef struct packed {
        logic        valid;
        logic        fresh;   // re-armed during the current expire
        logic        rpt;
        logic [7:0]  id;
        logic [47:0] deadline;
        logic [31:0] period;
    } entry_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CM_HOLD,
        CM_INSERT,
        CM_REMOVE,
        CM_POP,
        CM_UNFRESH
    } cell_mode_t;

endpackage

// File: rtl/core/deadline_timer_queue.sv
// Deadline-ordered timer queue.
// Request channel (in_valid/in_stall): opcode, event_id, deadline_ms, period_ms,
// repeat_req, now_ms. Opcode 0 adds a timer, 1 cancels the earliest timer with
// event_id, 2 fires every timer due at now_ms. Result channel
// (out_valid/out_stall): one transaction per fired timer, then a summary
// transaction with last=1 carrying has_next, next_interval_ms and status.
// Timers live in a chain of QUEUE_DEPTH cells kept sorted by deadline; every
// insert, removal or pop shifts the cells from the affected slot onward by one slot.
// An add or cancel updates the chain in S_ADD or S_CAN, then S_SUM writes the summary.
// An expire pops each due timer from the head in S_POP and re-inserts a fired
// repeating timer at now_ms + period in S_INS, then S_SUM writes the summary.
// A new request is taken once the summary is in the output register.
// Stall on the result side holds the output register and halts the sequence at its next result.
// Reset empties the queue and the output register; no clearing pass is needed.
module deadline_timer_queue
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  event_id,
    input  logic [47:0] deadline_ms,
    input  logic [31:0] period_ms,
    input  logic        repeat_req,
    input  logic [47:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        fired,
    output logic [7:0]  fired_id,
    output logic [47:0] fired_deadline_ms,
    output logic        has_next,
    output logic [47:0] next_interval_ms,
    output logic [1:0]  status,
    output logic        last
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADD  = 6'b000010,
        S_CAN  = 6'b000100,
        S_POP  = 6'b001000,
        S_INS  = 6'b010000,
        S_SUM  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Latched request
    logic [7:0]  req_id_reg;
    logic [47:0] req_dl_reg;
    logic [31:0] req_per_reg;
    logic        req_rpt_reg;
    logic [47:0] req_now_reg;
    logic [1:0]  stat_reg, stat_next;

    // Timer waiting for re-insertion
    logic [7:0]  rearm_id_reg;
    logic [47:0] rearm_dl_reg;
    logic [31:0] rearm_per_reg;

    // Output register
    logic        out_valid_reg;
    logic        fired_reg;
    logic [7:0]  fired_id_reg;
    logic [47:0] fired_dl_reg;
    logic        has_next_reg;
    logic [47:0] interval_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    // Cell chain
    dtq_pkg::entry_t     cell_ent [QUEUE_DEPTH];
    logic                cell_take [QUEUE_DEPTH];
    logic                cell_hit [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;
    dtq_pkg::cell_mode_t mode;
    dtq_pkg::entry_t     key;
    dtq_pkg::entry_t     empty_ent;

    logic        accept_in;
    logic        out_free;
    logic        full;
    logic        head_due;
    logic [48:0] rearm_sum;
    logic [47:0] rearm_dl;
    logic [47:0] interval;

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = cell_ent[QUEUE_DEPTH-1].valid;
    assign empty_ent = '0;

    // Head fires when due and not re-armed during this expire
    assign head_due = cell_ent[0].valid && !cell_ent[0].fresh &&
                      (cell_ent[0].deadline <= req_now_reg);

    // Saturating re-arm deadline
    assign rearm_sum = {1'b0, req_now_reg} + {17'd0, cell_ent[0].period};
    assign rearm_dl  = rearm_sum[48] ? {48{1'b1}} : rearm_sum[47:0];

    // Time to the earliest deadline
    always_comb
    begin
        if (!cell_ent[0].valid)
        begin
            interval = '0;
        end
        else if (cell_ent[0].deadline > req_now_reg)
        begin
            interval = cell_ent[0].deadline - req_now_reg;
        end
        else
        begin
            interval = dtq_pkg::IDLE_RETRY_MS;
        end
    end

    // Key and command for the chain
    always_comb
    begin
        key   = '{valid: 1'b1, fresh: 1'b0, rpt: req_rpt_reg, id: req_id_reg,
                  deadline: req_dl_reg, period: req_per_reg};
        mode  = dtq_pkg::CM_HOLD;
        unique case (state_reg)
            S_ADD:
            begin
                mode = full ? dtq_pkg::CM_HOLD : dtq_pkg::CM_INSERT;
            end
            S_CAN:
            begin
                mode = dtq_pkg::CM_REMOVE;
            end
            S_POP:
            begin
                mode = (head_due && out_free) ? dtq_pkg::CM_POP : dtq_pkg::CM_HOLD;
            end
            S_INS:
            begin
                key  = '{valid: 1'b1, fresh: 1'b1, rpt: 1'b1, id: rearm_id_reg,
                         deadline: rearm_dl_reg, period: rearm_per_reg};
                mode = dtq_pkg::CM_INSERT;
            end
            S_SUM:
            begin
                mode = out_free ? dtq_pkg::CM_UNFRESH : dtq_pkg::CM_HOLD;
            end
            default:
            begin
                mode = dtq_pkg::CM_HOLD;
            end
        endcase
    end

    // Chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            dtq_pkg::entry_t left_e;
            dtq_pkg::entry_t right_e;
            logic            left_t;
            logic            left_h;

            if (gi == 0)
            begin : g_first
                assign left_e = empty_ent;
                assign left_t = 1'b0;
                assign left_h = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_ent[gi-1];
                assign left_t = cell_take[gi-1];
                assign left_h = cell_hit[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = empty_ent;
            end
            else
            begin : g_inner
                assign right_e = cell_ent[gi+1];
            end

            dtq_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .mode      (mode),
                .key       (key),
                .left_ent  (left_e),
                .left_take (left_t),
                .left_hit  (left_h),
                .right_ent (right_e),
                .ent       (cell_ent[gi]),
                .take      (cell_take[gi]),
                .hit       (cell_hit[gi])
            );

            assign valid_vec[gi] = cell_ent[gi].valid;
        end
    endgenerate

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    stat_next = dtq_pkg::ST_OK;
                    case (opcode)
                        dtq_pkg::OP_ADD:    state_next = S_ADD;
                        dtq_pkg::OP_CANCEL: state_next = S_CAN;
                        dtq_pkg::OP_EXPIRE: state_next = S_POP;
                        default:            state_next = S_SUM;
                    endcase
                end
            end
            S_ADD:
            begin
                stat_next  = full ? dtq_pkg::ST_FULL : dtq_pkg::ST_OK;
                state_next = S_SUM;
            end
            S_CAN:
            begin
                stat_next  = cell_hit[QUEUE_DEPTH-1] ? dtq_pkg::ST_OK
                                                     : dtq_pkg::ST_NOT_FOUND;
                state_next = S_SUM;
            end
            S_POP:
            begin
                if (!head_due)
                begin
                    state_next = S_SUM;
                end
                else if (out_free && cell_ent[0].rpt)
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                state_next = S_POP;
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= dtq_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    // Request and re-arm capture
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            req_id_reg  <= event_id;
            req_dl_reg  <= deadline_ms;
            req_per_reg <= period_ms;
            req_rpt_reg <= repeat_req;
            req_now_reg <= now_ms;
        end
        if (mode == dtq_pkg::CM_POP)
        begin
            rearm_id_reg  <= cell_ent[0].id;
            rearm_dl_reg  <= rearm_dl;
            rearm_per_reg <= cell_ent[0].period;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_POP && head_due && out_free) ||
                 (state_reg == S_SUM && out_free))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_POP && head_due && out_free)
        begin
            fired_reg    <= 1'b1;
            fired_id_reg <= cell_ent[0].id;
            fired_dl_reg <= cell_ent[0].deadline;
            has_next_reg <= 1'b0;
            interval_reg <= '0;
            status_reg   <= dtq_pkg::ST_OK;
            last_reg     <= 1'b0;
        end
        else if (state_reg == S_SUM && out_free)
        begin
            fired_reg    <= 1'b0;
            fired_id_reg <= '0;
            fired_dl_reg <= '0;
            has_next_reg <= cell_ent[0].valid;
            interval_reg <= interval;
            status_reg   <= stat_reg;
            last_reg     <= 1'b1;
        end
    end

    assign out_valid         = out_valid_reg;
    assign fired             = fired_reg;
    assign fired_id          = fired_id_reg;
    assign fired_deadline_ms = fired_dl_reg;
    assign has_next          = has_next_reg;
    assign next_interval_ms  = interval_reg;
    assign status            = status_reg;
    assign last              = last_reg;

    // Occupied slots always form a prefix of the chain
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
        else $error("queue has a hole");

    // A reported timer was due at the request time
    a_due: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fired) |-> (fired_deadline_ms <= req_now_reg))
        else $error("fired timer not yet due");

    // No new request while a fired result is still pending
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |-> !(out_valid && fired))
        else $error("request accepted before expire finished");

endmodule

// File: rtl/core/dtq_cell.sv
module dtq_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::cell_mode_t mode,
    input  dtq_pkg::entry_t     key,
    input  dtq_pkg::entry_t     left_ent,
    input  logic                left_take,
    input  logic                left_hit,
    input  dtq_pkg::entry_t     right_ent,
    output dtq_pkg::entry_t     ent,
    output logic                take,
    output logic                hit
);

    logic        valid_reg, valid_next;
    logic        fresh_reg, fresh_next;
    logic        rpt_reg, rpt_next;
    logic [7:0]  id_reg, id_next;
    logic [47:0] dl_reg, dl_next;
    logic [31:0] per_reg, per_next;

    logic            load;
    dtq_pkg::entry_t src;

    assign ent = '{valid: valid_reg, fresh: fresh_reg, rpt: rpt_reg, id: id_reg,
                   deadline: dl_reg, period: per_reg};

    // Insert point: first slot that is empty or holds a later deadline
    assign take = !valid_reg || (dl_reg > key.deadline);
    // Removal: this slot or an earlier one holds the id
    assign hit  = left_hit || (valid_reg && (id_reg == key.id));

    // Pick the source of this slot's next contents
    always_comb
    begin
        load = 1'b0;
        src  = key;
        case (mode)
            dtq_pkg::CM_INSERT:
            begin
                if (left_take)
                begin
                    load = 1'b1;
                    src  = left_ent;
                end
                else if (take)
                begin
                    load = 1'b1;
                    src  = key;
                end
            end
            dtq_pkg::CM_REMOVE:
            begin
                if (hit)
                begin
                    load = 1'b1;
                    src  = right_ent;
                end
            end
            dtq_pkg::CM_POP:
            begin
                load = 1'b1;
                src  = right_ent;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = load ? src.valid    : valid_reg;
        fresh_next = load ? src.fresh    : fresh_reg;
        rpt_next   = load ? src.rpt      : rpt_reg;
        id_next    = load ? src.id       : id_reg;
        dl_next    = load ? src.deadline : dl_reg;
        per_next   = load ? src.period   : per_reg;
        if (mode == dtq_pkg::CM_UNFRESH)
        begin
            fresh_next = 1'b0;
        end
    end

    // Control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fresh_reg <= fresh_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        rpt_reg <= rpt_next;
        id_reg  <= id_next;
        dl_reg  <= dl_next;
        per_reg <= per_next;
    end

endmodule

// File: tb/tb_deadline_timer_queue.sv
module tb_deadline_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 20000;
    // Opcode with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One result of the block
    typedef struct packed {
        logic        fired;
        logic [7:0]  fired_id;
        logic [47:0] fired_deadline_ms;
        logic        has_next;
        logic [47:0] next_interval_ms;
        logic [1:0]  status;
        logic        last;
    } timer_result_t;

    typedef struct {
        logic [7:0]  id;
        logic [47:0] deadline;
        logic [31:0] period;
        logic        rpt;
    } timer_t;

    // Scoreboard: sorted timer table and the queue of expected results
    class timer_scoreboard;
        timer_t        table_q[$];
        timer_result_t pending_q[$];
        int            mismatches;
        int            checked;
        int            fired_seen;

        function void add_sorted(timer_t t);
            int pos;
            pos = table_q.size();
            for (int i = 0; i < table_q.size(); i++)
                if (table_q[i].deadline > t.deadline)
                begin
                    pos = i;
                    break;
                end
            table_q.insert(pos, t);
        endfunction

        function void push_summary(logic [47:0] now, logic [1:0] st);
            timer_result_t r;
            r = '0;
            r.last = 1'b1;
            r.status = st;
            if (table_q.size() > 0)
            begin
                r.has_next = 1'b1;
                r.next_interval_ms = (table_q[0].deadline > now) ?
                    table_q[0].deadline - now : dtq_pkg::IDLE_RETRY_MS;
            end
            pending_q.insert(pending_q.size(), r);
        endfunction

        // Work out the results of one accepted request
        function void note_request(logic [1:0] op, logic [7:0] id, logic [47:0] dl,
                                   logic [31:0] per, logic rpt, logic [47:0] now);
            timer_t        t;
            timer_t        fired_q[$];
            timer_result_t r;
            logic [48:0]   sum;
            logic [1:0]    st;
            st = dtq_pkg::ST_OK;
            if (op == dtq_pkg::OP_ADD)
            begin
                if (table_q.size() >= DEPTH)
                    st = dtq_pkg::ST_FULL;
                else
                begin
                    t.id = id; t.deadline = dl; t.period = per; t.rpt = rpt;
                    add_sorted(t);
                end
            end
            else if (op == dtq_pkg::OP_CANCEL)
            begin
                st = dtq_pkg::ST_NOT_FOUND;
                foreach (table_q[i])
                    if (table_q[i].id == id)
                    begin
                        table_q.delete(i);
                        st = dtq_pkg::ST_OK;
                        break;
                    end
            end
            else if (op == dtq_pkg::OP_EXPIRE)
            begin
                while (table_q.size() > 0 && table_q[0].deadline <= now)
                begin
                    t = table_q.pop_front();
                    r = '0;
                    r.fired = 1'b1;
                    r.fired_id = t.id;
                    r.fired_deadline_ms = t.deadline;
                    pending_q.insert(pending_q.size(), r);
                    fired_q.insert(fired_q.size(), t);
                end
                foreach (fired_q[i])
                    if (fired_q[i].rpt)
                    begin
                        t = fired_q[i];
                        sum = {1'b0, now} + {17'd0, t.period};
                        t.deadline = sum[48] ? MAX48 : sum[47:0];
                        add_sorted(t);
                    end
            end
            push_summary(now, st);
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            checked++;
            if (got.fired) fired_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected %p got %p", checked, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [7:0]  event_id;
    logic [47:0] deadline_ms;
    logic [31:0] period_ms;
    logic        repeat_req;
    logic [47:0] now_ms;
    logic        out_valid;
    logic        out_stall;
    logic        fired;
    logic [7:0]  fired_id;
    logic [47:0] fired_deadline_ms;
    logic        has_next;
    logic [47:0] next_interval_ms;
    logic [1:0]  status;
    logic        last;

    timer_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  requests_sent;
    logic [47:0] clock_ms;

    deadline_timer_queue #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls and result checks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result({fired, fired_id, fired_deadline_ms, has_next,
                                 next_interval_ms, status, last});
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one request and wait until it is taken
    task automatic send_request(logic [1:0] op, logic [7:0] id, logic [47:0] dl,
                                logic [31:0] per, logic rpt, logic [47:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        event_id    <= id;
        deadline_ms <= dl;
        period_ms   <= per;
        repeat_req  <= rpt;
        now_ms      <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(op, id, dl, per, rpt, now);
        requests_sent++;
    endtask

    task automatic send_random_request();
        int          pick;
        logic [1:0]  op;
        logic [7:0]  id;
        logic [47:0] dl;
        logic [31:0] per;
        pick = $urandom_range(99);
        // mostly a small working time with occasional full-range values
        clock_ms = clock_ms + 48'($urandom_range(40));
        id  = 8'($urandom_range(15));
        if ($urandom_range(9) == 0) id = 8'($urandom);
        dl  = clock_ms + 48'($urandom_range(200));
        per = 32'($urandom_range(150));
        if ($urandom_range(19) == 0)
        begin
            dl  = 48'({$urandom, $urandom});
            per = $urandom;
        end
        if (pick < 50) op = dtq_pkg::OP_ADD;
        else if (pick < 70) op = dtq_pkg::OP_CANCEL;
        else if (pick < 97) op = dtq_pkg::OP_EXPIRE;
        else op = OP_UNUSED;
        send_request(op, id, dl, per, 1'($urandom_range(1)), clock_ms);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = dtq_pkg::OP_ADD;
        event_id = '0;
        deadline_ms = '0;
        period_ms = '0;
        repeat_req = 1'b0;
        now_ms = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clock_ms = 48'd1000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, extremes, duplicates, full table, overflow
        send_request(dtq_pkg::OP_EXPIRE, 8'd0, '0, '0, 1'b0, '0);
        send_request(dtq_pkg::OP_CANCEL, 8'd9, '0, '0, 1'b0, '0);
        send_request(OP_UNUSED, 8'hFF, MAX48, 32'hFFFF_FFFF, 1'b1, MAX48);
        send_request(dtq_pkg::OP_ADD, 8'hFF, MAX48, 32'hFFFF_FFFF, 1'b1, 48'd0);
        send_request(dtq_pkg::OP_ADD, 8'h00, 48'd0, 32'd0, 1'b1, 48'd0);
        send_request(dtq_pkg::OP_ADD, 8'h00, 48'd5, 32'd7, 1'b0, 48'd0);
        for (int i = 0; i < 14; i++)
            send_request(dtq_pkg::OP_ADD, i[7:0] + 8'd1, 48'd5, 32'd3, i[0], 48'd0);
        send_request(dtq_pkg::OP_ADD, 8'hAA, 48'd1, 32'd1, 1'b0, 48'd0);
        send_request(dtq_pkg::OP_CANCEL, 8'h00, '0, '0, 1'b0, 48'd2);
        send_request(dtq_pkg::OP_EXPIRE, 8'd0, '0, '0, 1'b0, 48'd4);
        send_request(dtq_pkg::OP_EXPIRE, 8'd0, '0, '0, 1'b0, 48'd10);
        send_request(dtq_pkg::OP_EXPIRE, 8'd0, '0, '0, 1'b0, MAX48);
        drain();
        // empty whatever the directed part left behind
        for (int i = 0; i < 20; i++)
            send_request(dtq_pkg::OP_CANCEL,
                         sb.table_q.size() ? sb.table_q[0].id : 8'd0,
                         '0, '0, 1'b0, '0);

        // Random phases with differing idle and stall rates
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 60 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 60 : 0;
            if (ph == 3)
            begin
                send_idle_pct = 7;
                recv_stall_pct = 7;
            end
            for (int i = 0; i < 84; i++)
                send_random_request();
            drain();
        end

        // Long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_random_request();
        join
        drain();

        $display("Summary: %0d requests, %0d results checked, %0d fired timers",
                 requests_sent, sb.checked, sb.fired_seen);
        $display("Covered add, cancel, expire, unused opcode, full table and stalls");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/dtq_pkg.sv
rtl/core/dtq_cell.sv
rtl/core/deadline_timer_queue.sv
tb/tb_deadline_timer_queue.sv
